/* rtl/core/pcc_pkg.sv */
package pcc_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int SAMPLE_WIDTH   = 16;
    localparam int FRAC_BITS      = 8;
    localparam int SUM_WIDTH      = 32;
    localparam int SAMPLE_DIVISOR = 5;

    localparam int GAIN_WIDTH  = 16;
    localparam int DERIV_LIMIT = 5;
    localparam int OUT_FRAC    = 14;
    localparam int OUT_WIDTH   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_WIDTH;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_INTEGRAL_GAIN,
        REG_DERIV_GAIN,
        REG_FF_GAIN,
        REG_ENABLE
    } t_cfg_reg;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int ACC_W  = imax(SUM_WIDTH, ERR_W) + 1;

    localparam longint SUM_MAX = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // reciprocal that always overestimates, so one correction gives truncation
    localparam int     DIV_SHIFT = SAMPLE_WIDTH + 1 + 10;
    localparam int     DM_W      = DIV_SHIFT + 2;
    localparam longint DIV_MULT  = (longint'(1) << DIV_SHIFT) / SAMPLE_DIVISOR + 1;
    localparam int     DPROD_W   = DIFF_W + DM_W;

    localparam int DLIM  = DERIV_LIMIT * (2 ** FRAC_BITS);
    localparam int DER_W = $clog2(DLIM + 1) + 1;
    localparam int Q_W   = imax(DIFF_W + 1, DER_W);

    localparam int PI_W  = SUM_WIDTH + GAIN_WIDTH;
    localparam int PP_W  = ERR_W + GAIN_WIDTH;
    localparam int PF_W  = SAMPLE_WIDTH + GAIN_WIDTH;
    localparam int PD_W  = DER_W + GAIN_WIDTH;
    localparam int IP_W  = imax(PI_W, PP_W) + 1;
    localparam int PID_W = imax(IP_W, PD_W) + 1;
    localparam int CL_W  = 2 * FRAC_BITS + 2;
    localparam int TOT_W = imax(CL_W, PF_W) + 1;

    localparam longint ONE = longint'(1) << (2 * FRAC_BITS);

    localparam int OUT_RSHIFT = (2 * FRAC_BITS >= OUT_FRAC) ? 2 * FRAC_BITS - OUT_FRAC : 0;
    localparam int OUT_LSHIFT = (2 * FRAC_BITS >= OUT_FRAC) ? 0 : OUT_FRAC - 2 * FRAC_BITS;
    localparam int SH_W       = CL_W + OUT_LSHIFT;
    localparam int OUT_FULL   = 1 << OUT_FRAC;

endpackage

/* rtl/core/pcc_in_if.sv */
interface pcc_in_if import pcc_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

/* rtl/core/pcc_out_if.sv */
interface pcc_out_if import pcc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] drive;
    logic                        limited;

    modport source (output valid, output drive, output limited, input ready);
    modport sink   (input valid, input drive, input limited, output ready);
endinterface

/* rtl/core/pid_controller_clamped_top.sv */
// channel   dir  handshake       payload
// i_req     in   valid / ready   setpoint, measured (signed q8.8)
// o_rsp     out  valid / ready   drive (signed q2.14), limited
// i_cfg     in   write enable    index, data
//
// one request accepted per cycle while ready is high; its result reaches the output
// register after stages one to five, through the six register stages of the pipeline
// integral and previous error update in the accept cycle, so requests follow back to back
// a stalled output holds its result; empty stages still take requests, and
// ready falls only once every stage is full
// synchronous active-low reset clears the gains, enable, state and valids
module pid_controller_clamped_top import pcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcc_in_if.sink                i_req,
    pcc_out_if.source             o_rsp
);

    logic signed [GAIN_WIDTH-1:0] r_prop_gain;
    logic signed [GAIN_WIDTH-1:0] r_integral_gain;
    logic signed [GAIN_WIDTH-1:0] r_deriv_gain;
    logic signed [GAIN_WIDTH-1:0] r_ff_gain;
    logic                         r_enable;

    logic signed [SUM_WIDTH-1:0] r_error_sum;
    logic signed [ERR_W-1:0]     r_last_error;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic en_1, en_2, en_3, en_4, en_5, en_out;
    logic take;

    logic signed [ERR_W-1:0]        r1_err;
    logic signed [SUM_WIDTH-1:0]    r1_sum;
    logic signed [DIFF_W-1:0]       r1_diff;
    logic signed [SAMPLE_WIDTH-1:0] r1_sp;
    logic                           r1_act;

    logic signed [DPROD_W-1:0] r2_dprod;
    logic                      r2_dneg;
    logic signed [PI_W-1:0]    r2_pi;
    logic signed [PP_W-1:0]    r2_pp;
    logic signed [PF_W-1:0]    r2_pf;
    logic                      r2_act;

    logic signed [DER_W-1:0] r3_deriv;
    logic signed [IP_W-1:0]  r3_ip;
    logic signed [PF_W-1:0]  r3_pf;
    logic                    r3_act;

    logic signed [PD_W-1:0] r4_pd;
    logic signed [IP_W-1:0] r4_ip;
    logic signed [PF_W-1:0] r4_pf;
    logic                   r4_act;

    logic signed [CL_W-1:0] r5_pid;
    logic signed [PF_W-1:0] r5_pf;
    logic                   r5_act;

    logic signed [OUT_WIDTH-1:0] r_drive;
    logic                        r_limited;

    logic signed [ERR_W-1:0]     n_err;
    logic signed [ACC_W-1:0]     n_acc;
    logic signed [SUM_WIDTH-1:0] n_error_sum;
    logic signed [DIFF_W-1:0]    n_diff;
    logic                        n_act;
    logic signed [Q_W-1:0]       n_qsh;
    logic signed [Q_W-1:0]       n_q;
    logic signed [DER_W-1:0]     n_deriv;
    logic signed [IP_W-1:0]      n_ip;
    logic signed [PID_W-1:0]     n_pid_raw;
    logic signed [CL_W-1:0]      n_pid;
    logic signed [TOT_W-1:0]     n_tot;
    logic signed [CL_W-1:0]      n_tot_cl;
    logic signed [SH_W-1:0]      n_sh;
    logic                        n_limited;
    logic signed [OUT_WIDTH-1:0] n_drive;

    localparam logic signed [DM_W-1:0] DIV_MULT_S = DM_W'(DIV_MULT);

    // handshake and stage enables
    assign en_out = !r_ov || o_rsp.ready;
    assign en_5   = !r_v5 || en_out;
    assign en_4   = !r_v4 || en_5;
    assign en_3   = !r_v3 || en_4;
    assign en_2   = !r_v2 || en_3;
    assign en_1   = !r_v1 || en_2;
    assign take   = i_req.valid && en_1;

    assign i_req.ready   = en_1;
    assign o_rsp.valid   = r_ov;
    assign o_rsp.drive   = r_drive;
    assign o_rsp.limited = r_limited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= '0;
            r_integral_gain <= '0;
            r_deriv_gain    <= '0;
            r_ff_gain       <= '0;
            r_enable        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                REG_INTEGRAL_GAIN: r_integral_gain <= i_cfg_data;
                REG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_data;
                REG_FF_GAIN:       r_ff_gain       <= i_cfg_data;
                REG_ENABLE:        r_enable        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en_1)   r_v1 <= i_req.valid;
            if (en_2)   r_v2 <= r_v1;
            if (en_3)   r_v3 <= r_v2;
            if (en_4)   r_v4 <= r_v3;
            if (en_5)   r_v5 <= r_v4;
            if (en_out) r_ov <= r_v5;
        end
    end

    // error, saturating integral, difference
    always_comb begin
        n_err = ERR_W'(i_req.setpoint) - ERR_W'(i_req.measured);
        n_acc = ACC_W'(r_error_sum) + ACC_W'(n_err);
        if (n_acc > ACC_W'(SUM_MAX)) begin
            n_error_sum = SUM_WIDTH'(SUM_MAX);
        end else if (n_acc < ACC_W'(SUM_MIN)) begin
            n_error_sum = SUM_WIDTH'(SUM_MIN);
        end else begin
            n_error_sum = n_acc[SUM_WIDTH-1:0];
        end
        n_diff = DIFF_W'(r_last_error) - DIFF_W'(n_err);
        n_act  = r_enable && (i_req.setpoint != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (take) begin
            r_error_sum  <= n_error_sum;
            r_last_error <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_1) begin
            r1_err  <= n_err;
            r1_sum  <= n_error_sum;
            r1_diff <= n_diff;
            r1_sp   <= i_req.setpoint;
            r1_act  <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_2) begin
            r2_dprod <= r1_diff * DIV_MULT_S;
            r2_dneg  <= r1_diff[DIFF_W-1];
            r2_pi    <= r1_sum * r_integral_gain;
            r2_pp    <= r1_err * r_prop_gain;
            r2_pf    <= r1_sp * r_ff_gain;
            r2_act   <= r1_act;
        end
    end

    // quotient truncated toward zero, then derivative clamp
    always_comb begin
        n_qsh = Q_W'(r2_dprod >>> DIV_SHIFT);
        n_q   = r2_dneg ? n_qsh + Q_W'(1) : n_qsh;
        if (n_q > Q_W'(DLIM)) begin
            n_deriv = DER_W'(DLIM);
        end else if (n_q < Q_W'(-DLIM)) begin
            n_deriv = DER_W'(-DLIM);
        end else begin
            n_deriv = n_q[DER_W-1:0];
        end
        n_ip = IP_W'(r2_pi) + IP_W'(r2_pp);
    end

    always_ff @(posedge i_clk) begin
        if (en_3) begin
            r3_deriv <= n_deriv;
            r3_ip    <= n_ip;
            r3_pf    <= r2_pf;
            r3_act   <= r2_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_4) begin
            r4_pd  <= r3_deriv * r_deriv_gain;
            r4_ip  <= r3_ip;
            r4_pf  <= r3_pf;
            r4_act <= r3_act;
        end
    end

    always_comb begin
        n_pid_raw = PID_W'(r4_ip) + PID_W'(r4_pd);
        if (n_pid_raw > PID_W'(ONE)) begin
            n_pid = CL_W'(ONE);
        end else if (n_pid_raw < PID_W'(-ONE)) begin
            n_pid = CL_W'(-ONE);
        end else begin
            n_pid = n_pid_raw[CL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_5) begin
            r5_pid <= n_pid;
            r5_pf  <= r4_pf;
            r5_act <= r4_act;
        end
    end

    // feedforward, final clamp, floor to q2.14
    always_comb begin
        n_tot     = TOT_W'(r5_pid) + TOT_W'(r5_pf);
        n_limited = 1'b0;
        n_tot_cl  = n_tot[CL_W-1:0];
        if (n_tot > TOT_W'(ONE)) begin
            n_limited = 1'b1;
            n_tot_cl  = CL_W'(ONE);
        end else if (n_tot < TOT_W'(-ONE)) begin
            n_limited = 1'b1;
            n_tot_cl  = CL_W'(-ONE);
        end
        n_sh    = (SH_W'(n_tot_cl) <<< OUT_LSHIFT) >>> OUT_RSHIFT;
        n_drive = r5_act ? n_sh[OUT_WIDTH-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_drive   <= n_drive;
            r_limited <= n_limited && r5_act;
        end
    end

`ifndef ASSERT_OFF
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v1)
        else $error("accepted request did not enter the first stage");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.valid && i_req.ready) |=> ($stable(r_error_sum) && $stable(r_last_error)))
        else $error("integral or previous error changed without a request");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_ov && !o_rsp.ready))
        else $error("ready low while the pipeline has room");

    a_limit_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_limited) |->
            (r_drive == OUT_WIDTH'(OUT_FULL) || r_drive == OUT_WIDTH'(-OUT_FULL)))
        else $error("limited result not at full scale");
`endif

endmodule
